FILE: sv/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg - shared types and constants of the RMS level meter
// Field widths, register indexes, reset values and the status struct of the
// iterative arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package rms_pkg;

  localparam int OVERSAMPLING_DEF = 2;

  localparam int SAMPLE_W = 16;
  localparam int DECIM_W  = 23;
  localparam int OFFSET_W = 40;
  localparam int SQSUM_W  = 64;
  localparam int WIN_W    = 16;
  localparam int COEFF_W  = 16;
  localparam int GAIN_W   = 32;
  localparam int AMP_W    = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_COEFF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 2'd2;

  localparam logic [WIN_W-1:0]   WINDOW_LENGTH_RST = 16'd320;
  localparam logic [COEFF_W-1:0] OFFSET_COEFF_RST  = 16'd66;
  localparam logic [GAIN_W-1:0]  GAIN_RST          = 32'd65536;

  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  localparam int SQRT_IN_W  = 64;
  localparam int SQRT_OUT_W = SQRT_IN_W / 2;
  localparam int SQRT_REM_W = SQRT_OUT_W + 3;
  localparam int SQRT_CNT_W = $clog2(SQRT_OUT_W);

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

FILE: sv/rms_mul.sv
// ----------------------------------------------------------------------------
// rms_mul - shared shift-add multiplier
// Unsigned 64 x 32 product, one multiplier bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_mul
  import rms_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output      logic [MUL_P_W-1:0] prod,
  output      unit_stat_t         stat
);

  logic [MUL_A_W-1:0]   a_reg;
  logic [MUL_CNT_W-1:0] cnt;
  logic [MUL_A_W:0]     upper;

  always_comb begin
    upper = {1'b0, prod[MUL_P_W-1:MUL_B_W]} + (prod[0] ? {1'b0, a_reg} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      prod  <= {{MUL_A_W{1'b0}}, b};
    end else if (stat.busy) begin
      prod <= {upper, prod[MUL_B_W-1:1]};
    end
  end

endmodule

`default_nettype wire

FILE: sv/rms_isqrt.sv
// ----------------------------------------------------------------------------
// rms_isqrt - digit-by-digit integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_isqrt
  import rms_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [SQRT_IN_W-1:0]  v,
  output      logic [SQRT_OUT_W-1:0] root,
  output      unit_stat_t            stat
);

  logic [SQRT_IN_W-1:0]  v_sh;
  logic [SQRT_REM_W-1:0] rem;
  logic [SQRT_REM_W-1:0] r2;
  logic [SQRT_REM_W-1:0] trial;
  logic [SQRT_CNT_W-1:0] cnt;

  always_comb begin
    r2    = {rem[SQRT_REM_W-3:0], v_sh[SQRT_IN_W-1:SQRT_IN_W-2]};
    trial = {1'b0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == SQRT_CNT_W'(SQRT_OUT_W - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_sh <= v;
      rem  <= '0;
      root <= '0;
    end else if (stat.busy) begin
      v_sh <= {v_sh[SQRT_IN_W-3:0], 2'b00};
      if (r2 >= trial) begin
        rem  <= r2 - trial;
        root <= {root[SQRT_OUT_W-2:0], 1'b1};
      end else begin
        rem  <= r2;
        root <= {root[SQRT_OUT_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/rms_level_meter.sv
// ----------------------------------------------------------------------------
// rms_level_meter - RMS level meter with DC removal
// Decimates PCM samples, tracks and removes the DC offset and emits the RMS
// amplitude of each window of decimated values.
// ----------------------------------------------------------------------------
// Input requests (sample) are taken on in_valid with in_stall low. A sample
// that does not complete a decimated value is added to the decimation sum
// and the sequencer stays in S_IDLE. A sample that completes one runs the
// sequencer through S_DIFF, S_MULC, S_DEV and S_MULS: the DC update and the
// square each run on the shared shift-add multiplier. When the window
// closes, the gain product (S_MULG) and the square root (S_SQRT) follow,
// the amplitude request appears on out_valid after S_OUT and the next
// sample is taken once the sequencer is back in S_IDLE.
// in_stall is high while the sequencer works. A finished result waits in the
// output register while out_stall is high; a new sample is still taken then,
// and only a second result waits for the register to drain.
// Configuration writes (cfg_index, cfg_data) are taken every cycle and act
// at once. Reset clears the sequencer, the accumulators and the output valid,
// and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_level_meter
  import rms_pkg::*;
#(
  parameter int OVERSAMPLING = OVERSAMPLING_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic [SAMPLE_W-1:0]   sample,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic [AMP_W-1:0]      amplitude,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PH_W = (OVERSAMPLING > 1) ? $clog2(OVERSAMPLING) : 1;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIFF = 9'b000000010,
    S_MULC = 9'b000000100,
    S_DEV  = 9'b000001000,
    S_MULS = 9'b000010000,
    S_GAIN = 9'b000100000,
    S_MULG = 9'b001000000,
    S_SQRT = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state;

  logic [WIN_W-1:0]   window_length;
  logic [COEFF_W-1:0] offset_coeff;
  logic [GAIN_W-1:0]  gain;

  logic [PH_W-1:0]           phase_count;
  logic signed [DECIM_W-1:0] decim_sum;
  logic signed [DECIM_W-1:0] d;
  logic signed [OFFSET_W-1:0] dc_offset;
  logic [SQSUM_W-1:0]        square_sum;
  logic [WIN_W-1:0]          window_count;
  logic                      diff_neg;

  logic [PH_W:0]              phase_inc;
  logic signed [DECIM_W-1:0]  decim_next;
  logic signed [OFFSET_W:0]   diff;
  logic [OFFSET_W:0]          diff_abs;
  logic signed [OFFSET_W:0]   off_round;
  logic signed [OFFSET_W-16:0] r;
  logic signed [OFFSET_W-14:0] dev;
  logic [OFFSET_W-14:0]       dev_abs;
  logic signed [56:0]         delta_full;
  logic [SQSUM_W:0]           sq_sum;
  logic [WIN_W:0]             win_next;
  logic [SQRT_IN_W-1:0]       scaled;
  logic                       out_load;

  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  unit_stat_t         mul_stat;

  logic                  sqrt_start;
  logic [SQRT_OUT_W-1:0] sqrt_root;
  unit_stat_t            sqrt_stat;

  rms_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_p),
    .stat  (mul_stat)
  );

  rms_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .v     (scaled),
    .root  (sqrt_root),
    .stat  (sqrt_stat)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_load  = (state == S_OUT) && (!out_valid || !out_stall);

  always_comb begin
    phase_inc  = {1'b0, phase_count} + 1'b1;
    decim_next = decim_sum + DECIM_W'(signed'(sample));
    diff       = $signed({d[DECIM_W-1], d, 16'h0000}) - (OFFSET_W+1)'(dc_offset);
    diff_abs   = diff[OFFSET_W] ? unsigned'(-diff) : unsigned'(diff);
    delta_full = diff_neg ? -$signed({1'b0, mul_p[55:0]}) : $signed({1'b0, mul_p[55:0]});
    off_round  = (OFFSET_W+1)'(dc_offset) + (OFFSET_W+1)'(32768);
    r          = off_round[OFFSET_W:16];
    dev        = (OFFSET_W-13)'(d) - (OFFSET_W-13)'(r);
    dev_abs    = dev[OFFSET_W-14] ? unsigned'(-dev) : unsigned'(dev);
    sq_sum     = {1'b0, square_sum} + {1'b0, mul_p[SQSUM_W-1:0]};
    win_next   = {1'b0, window_count} + 1'b1;
    scaled     = (mul_p[MUL_P_W-1:SQRT_IN_W+16] != '0) ? '1 : mul_p[SQRT_IN_W+15:16];
  end

  always_comb begin
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    unique case (state)
      S_DIFF: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(diff_abs);
        mul_b     = MUL_B_W'(offset_coeff);
      end
      S_DEV: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(dev_abs);
        mul_b     = MUL_B_W'(dev_abs);
      end
      S_GAIN: begin
        mul_start = 1'b1;
        mul_a     = square_sum;
        mul_b     = gain;
      end
      S_MULG: begin
        sqrt_start = mul_stat.done;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RST;
      offset_coeff  <= OFFSET_COEFF_RST;
      gain          <= GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data[WIN_W-1:0];
        REG_OFFSET_COEFF:  offset_coeff  <= cfg_data[COEFF_W-1:0];
        REG_GAIN:          gain          <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase_count  <= '0;
      decim_sum    <= '0;
      dc_offset    <= '0;
      square_sum   <= '0;
      window_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (phase_inc >= (PH_W+1)'(OVERSAMPLING)) begin
              phase_count <= '0;
              decim_sum   <= '0;
              d           <= decim_next;
              state       <= S_DIFF;
            end else begin
              phase_count <= phase_inc[PH_W-1:0];
              decim_sum   <= decim_next;
            end
          end
        end
        S_DIFF: begin
          diff_neg <= diff[OFFSET_W];
          state    <= S_MULC;
        end
        S_MULC: begin
          if (mul_stat.done) begin
            dc_offset <= dc_offset + OFFSET_W'(delta_full >>> 16);
            state     <= S_DEV;
          end
        end
        S_DEV: begin
          state <= S_MULS;
        end
        S_MULS: begin
          if (mul_stat.done) begin
            square_sum <= sq_sum[SQSUM_W] ? '1 : sq_sum[SQSUM_W-1:0];
            if (win_next < {1'b0, window_length}) begin
              window_count <= win_next[WIN_W-1:0];
              state        <= S_IDLE;
            end else begin
              window_count <= '0;
              state        <= S_GAIN;
            end
          end
        end
        S_GAIN: begin
          state <= S_MULG;
        end
        S_MULG: begin
          if (mul_stat.done) begin
            square_sum <= '0;
            state      <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_stat.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      amplitude <= sqrt_root;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rms_level_meter_chk.sv
// ----------------------------------------------------------------------------
// rms_level_meter_chk - port checker for the RMS level meter
// Watches the top-level ports over time; bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_level_meter_chk
  import rms_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic [SAMPLE_W-1:0]   sample,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [AMP_W-1:0]      amplitude,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready
);

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  a_request_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(sample))
    else $error("stalled sample request changed");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(amplitude))
    else $error("stalled result request changed");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration request refused");

endmodule

bind rms_level_meter rms_level_meter_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .sample    (sample),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .amplitude (amplitude),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
